// File: sv/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and the quarter-wave sine table of the SVPWM block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int SQRT3_HALF_Q15      = 28378;
    localparam int INV_SQRT3_Q16       = 37837;
    localparam int QUEUE_DEPTH         = 2;
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;

    localparam logic [2:0] SECTOR_NONE = 3'd0;
    localparam logic [2:0] SECTOR_1    = 3'd1;
    localparam logic [2:0] SECTOR_2    = 3'd2;
    localparam logic [2:0] SECTOR_3    = 3'd3;
    localparam logic [2:0] SECTOR_4    = 3'd4;
    localparam logic [2:0] SECTOR_5    = 3'd5;
    localparam logic [2:0] SECTOR_6    = 3'd6;

    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
        16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
        16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
        16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847,
        16'd18324, 16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763, 16'd23170,
        16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102, 16'd25466,
        16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
        16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
        16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651,
        16'd31795, 16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365,
        16'd32449, 16'd32524, 16'd32588, 16'd32643, 16'd32688, 16'd32723,
        16'd32748, 16'd32763, 16'd32768
    };

    // One classified request: clamped command magnitudes with their signs.
    typedef struct packed {
        logic        zero_bus;
        logic [14:0] bus;
        logic        q_neg;
        logic [14:0] q_mag;
        logic        d_neg;
        logic [14:0] d_mag;
        logic        ang_neg;
        logic [31:0] ang_mag;
    } svpwm_req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_ANG, ST_SIN, ST_COS, ST_ROT1, ST_ROT2,
        ST_SUM, ST_BS, ST_SECT, ST_T0, ST_T1, ST_DUTY, ST_DONE
    } svpwm_state_t;

endpackage

// File: sv/svpwm_in_if.sv
// ----------------------------------------------------------------------------
// svpwm_in_if
// Request channel: bus voltage, dq voltage commands and electrical angle.
// ----------------------------------------------------------------------------
interface svpwm_in_if;
    logic               valid;
    logic               ready;
    logic        [14:0] bus_voltage;
    logic signed [15:0] q_voltage;
    logic signed [15:0] d_voltage;
    logic signed [31:0] electrical_angle;

    modport source (output valid, bus_voltage, q_voltage, d_voltage, electrical_angle,
                    input ready);
    modport sink   (input valid, bus_voltage, q_voltage, d_voltage, electrical_angle,
                    output ready);
endinterface

// File: sv/svpwm_out_if.sv
// ----------------------------------------------------------------------------
// svpwm_out_if
// Result channel: three phase compare values and the voltage sector.
// ----------------------------------------------------------------------------
interface svpwm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pwm_a;
    logic [15:0] pwm_b;
    logic [15:0] pwm_c;
    logic [2:0]  sector;

    modport source (output valid, pwm_a, pwm_b, pwm_c, sector, input ready);
    modport sink   (input valid, pwm_a, pwm_b, pwm_c, sector, output ready);
endinterface

// File: sv/svpwm_inverse_park_duty_calc.sv
// ----------------------------------------------------------------------------
// svpwm_inverse_park_duty_calc
// Space vector PWM duty calculation with inverse Park rotation.
// ----------------------------------------------------------------------------
// The single shared sequencer takes one request at a time and pops the next
// only after the result register has taken the last result: shift-subtract
// division with the angle reduction alongside, then one step each. A zero bus
// voltage goes straight to the result. A two-entry queue takes requests while busy.
// Reset: queue and sequencer empty, no result pending, period count 1000.
module svpwm_inverse_park_duty_calc
    import svpwm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    svpwm_in_if.sink    cmd,
    svpwm_out_if.source duty,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] pwm_period_reg;
    logic        push;
    logic        queue_full;
    logic        req_valid;
    logic        req_pop;
    svpwm_req_t  front_req;
    svpwm_req_t  back_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PWM_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            pwm_period_reg <= cfg_wr_data;
        end
    end

    svpwm_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .req        (front_req)
    );

    svpwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_req),
        .full      (queue_full),
        .pop       (req_pop),
        .not_empty (req_valid),
        .pop_data  (back_req)
    );

    svpwm_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (back_req),
        .req_pop    (req_pop),
        .pwm_period (pwm_period_reg),
        .rsp        (duty)
    );

    a_pop_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> req_valid)
        else $error("request popped from an empty queue");

    a_zero_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (duty.valid && duty.sector == SECTOR_NONE) |->
        (duty.pwm_a == '0 && duty.pwm_b == '0 && duty.pwm_c == '0))
        else $error("sector zero with nonzero compare values");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty.valid |-> (duty.sector <= SECTOR_6))
        else $error("sector out of range");

endmodule

// File: sv/svpwm_front.sv
// ----------------------------------------------------------------------------
// svpwm_front
// Accepts requests, clamps the commands to the bus and splits sign/magnitude.
// ----------------------------------------------------------------------------
module svpwm_front
    import svpwm_pkg::*;
(
    svpwm_in_if.sink   cmd,
    input  logic       queue_full,
    output logic       push,
    output svpwm_req_t req
);

    logic [16:0] q_abs;
    logic [16:0] d_abs;

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    assign q_abs = cmd.q_voltage[15] ? 17'(-$signed({cmd.q_voltage[15], cmd.q_voltage}))
                                     : 17'(cmd.q_voltage);
    assign d_abs = cmd.d_voltage[15] ? 17'(-$signed({cmd.d_voltage[15], cmd.d_voltage}))
                                     : 17'(cmd.d_voltage);

    always_comb
    begin
        req.zero_bus = (cmd.bus_voltage == 15'd0);
        req.bus      = cmd.bus_voltage;
        req.q_neg    = cmd.q_voltage[15];
        req.q_mag    = (q_abs > 17'(cmd.bus_voltage)) ? cmd.bus_voltage : q_abs[14:0];
        req.d_neg    = cmd.d_voltage[15];
        req.d_mag    = (d_abs > 17'(cmd.bus_voltage)) ? cmd.bus_voltage : d_abs[14:0];
        req.ang_neg  = cmd.electrical_angle[31];
        req.ang_mag  = cmd.electrical_angle[31] ? 32'(-cmd.electrical_angle)
                                                : 32'(cmd.electrical_angle);
    end

endmodule

// File: sv/svpwm_queue.sv
// ----------------------------------------------------------------------------
// svpwm_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module svpwm_queue
    import svpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  svpwm_req_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output svpwm_req_t pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    svpwm_req_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/svpwm_back.sv
// ----------------------------------------------------------------------------
// svpwm_back
// Sequencer: dq scaling by division, angle reduction, inverse Park, sectors
// and duty counts, with a result register toward the output channel.
// ----------------------------------------------------------------------------
module svpwm_back
    import svpwm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  svpwm_req_t  req,
    output logic        req_pop,
    input  logic [15:0] pwm_period,
    svpwm_out_if.source rsp
);

    localparam int FULL = 360 << ANGLE_FRAC_BITS;
    localparam int AW   = $clog2(FULL + 1);
    localparam int TW   = 56;
    localparam int SH   = ANGLE_FRAC_BITS + 3;
    localparam int MOD45 = 45;
    localparam int REC45 = 5826;
    localparam logic [31:0] LOW_M = 32'((64'd1 << SH) - 64'd1);
    localparam logic [AW-1:0] FULL_A  = AW'(FULL);
    localparam logic [AW-1:0] HALF_A  = AW'(180 << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0] QUART_A = AW'(90 << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0] FRAC_M  = AW'((1 << ANGLE_FRAC_BITS) - 1);
    localparam logic [AW-1:0] UNIT_A  = AW'(1 << ANGLE_FRAC_BITS);
    localparam logic signed [TW-1:0] ONE   = TW'(64'sd1 << 46);
    localparam logic signed [TW-1:0] K_INV = TW'(INV_SQRT3_Q16);

    typedef struct packed {
        logic [14:0] rem;
        logic [15:0] sh;
        logic [15:0] quo;
    } div_t;

    svpwm_state_t state_reg, state_next;
    logic [2:0]   cnt_reg, cnt_next;

    logic [14:0]  bus_reg;
    logic         q_neg_reg, d_neg_reg, ang_neg_reg;
    div_t         qdiv_reg, qdiv_next, ddiv_reg, ddiv_next;
    logic [AW-1:0] arem_reg;
    logic [31:0]  ash_reg;
    logic [12:0]  afold_reg;
    logic [AW-1:0] ang_reg, ang90_reg;
    logic signed [15:0] uq_reg, ud_reg;
    logic signed [16:0] s_reg, c_reg;
    logic signed [32:0] pa_reg, pb_reg;
    logic signed [33:0] alpha_reg, beta_reg;
    logic signed [TW-1:0] bs_reg, t1_reg, t2_reg, t0_reg;
    logic signed [TW-1:0] ta_reg, tb_reg, tc_reg;
    logic [2:0]   sector_reg;
    logic [15:0]  duty_a_reg, duty_b_reg, duty_c_reg;

    logic         rsp_valid_reg;
    logic [15:0]  rsp_a_reg, rsp_b_reg, rsp_c_reg;
    logic [2:0]   rsp_sector_reg;
    logic         rsp_load;

    logic [29:0]  q_prod, d_prod;
    logic [31:0]  ang_hi;
    logic [13:0]  ang_fold1;
    logic [12:0]  ang_fold2;
    logic [25:0]  ang_qprod;
    logic [12:0]  ang_rem;
    logic [AW-1:0] ang_fix;
    logic [AW:0]  ang90_sum;
    logic [AW-1:0] trig_in;
    logic signed [16:0] trig_out;
    logic signed [TW-1:0] a_w, b2_w, t1_w, t2_w;
    logic [2:0]   sector_w;
    logic signed [TW-1:0] tsel;
    logic [46:0]  tclamp;
    logic [62:0]  duty_prod;

    // Two restoring quotient bits per cycle.
    function automatic div_t div_step2(input div_t x, input logic [14:0] dv);
        div_t        y;
        logic [15:0] r2;
        y = x;
        for (int k = 0; k < 2; k++)
        begin
            r2   = {y.rem, y.sh[15]};
            y.sh = {y.sh[14:0], 1'b0};
            if (r2 >= {1'b0, dv})
            begin
                y.rem = 15'(r2 - {1'b0, dv});
                y.quo = {y.quo[14:0], 1'b1};
            end
            else
            begin
                y.rem = r2[14:0];
                y.quo = {y.quo[14:0], 1'b0};
            end
        end
        return y;
    endfunction

    // Quarter-wave sine with linear interpolation, input in [0, 360 deg).
    function automatic logic signed [16:0] sine_of(input logic [AW-1:0] deg_in);
        logic          neg;
        logic [AW-1:0] d;
        logic [6:0]    idx;
        logic [AW-1:0] frac;
        logic [31:0]   acc;
        logic [16:0]   v;
        neg = (deg_in > HALF_A);
        d   = neg ? deg_in - HALF_A : deg_in;
        if (d > QUART_A)
        begin
            d = HALF_A - d;
        end
        idx  = 7'(d >> ANGLE_FRAC_BITS);
        frac = d & FRAC_M;
        if (idx >= 7'd90)
        begin
            v = 17'd32768;
        end
        else
        begin
            acc = 32'(SINE_Q15[idx]) * 32'(UNIT_A - frac)
                + 32'(SINE_Q15[idx + 7'd1]) * 32'(frac);
            v = 17'(acc >> ANGLE_FRAC_BITS);
        end
        return neg ? -$signed(v) : $signed(v);
    endfunction

    assign q_prod    = 30'(req.q_mag) * 30'(SQRT3_HALF_Q15);
    assign d_prod    = 30'(req.d_mag) * 30'(SQRT3_HALF_Q15);

    // A full turn is 45 << SH. Since 2^12 is 1 modulo 45, the part above SH
    // folds in 12-bit chunks, and a reciprocal multiply takes the rest.
    assign ang_hi    = ash_reg >> SH;
    assign ang_fold1 = 14'(ang_hi[11:0]) + 14'(ang_hi[23:12]) + 14'(ang_hi[31:24]);
    assign ang_fold2 = 13'(ang_fold1[11:0]) + 13'(ang_fold1[13:12]);
    assign ang_qprod = 26'(afold_reg) * 26'(REC45);
    assign ang_rem   = afold_reg - 13'(ang_qprod[25:18]) * 13'(MOD45);

    assign ang_fix   = (ang_neg_reg && arem_reg != '0) ? FULL_A - arem_reg : arem_reg;
    assign ang90_sum = {1'b0, ang_fix} + {1'b0, QUART_A};
    assign trig_in   = (state_reg == ST_SIN) ? ang_reg : ang90_reg;
    assign trig_out  = sine_of(trig_in);

    assign a_w  = TW'(alpha_reg) <<< 16;
    assign b2_w = bs_reg <<< 1;

    always_comb
    begin
        if (!beta_reg[33])
        begin
            if (!alpha_reg[33])
            begin
                sector_w = (a_w < bs_reg) ? SECTOR_2 : SECTOR_1;
            end
            else
            begin
                sector_w = (a_w < -bs_reg) ? SECTOR_3 : SECTOR_2;
            end
        end
        else
        begin
            if (!alpha_reg[33])
            begin
                sector_w = (a_w < -bs_reg) ? SECTOR_5 : SECTOR_6;
            end
            else
            begin
                sector_w = (a_w < bs_reg) ? SECTOR_4 : SECTOR_5;
            end
        end
        case (sector_w)
            SECTOR_1: begin t1_w = a_w - bs_reg;  t2_w = b2_w;           end
            SECTOR_2: begin t1_w = a_w + bs_reg;  t2_w = bs_reg - a_w;   end
            SECTOR_3: begin t1_w = b2_w;          t2_w = -a_w - bs_reg;  end
            SECTOR_4: begin t1_w = bs_reg - a_w;  t2_w = -b2_w;          end
            SECTOR_5: begin t1_w = -a_w - bs_reg; t2_w = a_w - bs_reg;   end
            default:  begin t1_w = -b2_w;         t2_w = a_w + bs_reg;   end
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            3'd0:    tsel = ta_reg;
            3'd1:    tsel = tb_reg;
            default: tsel = tc_reg;
        endcase
        if (tsel < 0)
        begin
            tclamp = '0;
        end
        else if (tsel > ONE)
        begin
            tclamp = 47'(ONE);
        end
        else
        begin
            tclamp = 47'(tsel);
        end
        duty_prod = 63'(tclamp) * 63'(pwm_period);
    end

    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_pop    = 1'b0;
        qdiv_next  = div_step2(qdiv_reg, bus_reg);
        ddiv_next  = div_step2(ddiv_reg, bus_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop    = 1'b1;
                    cnt_next   = '0;
                    state_next = req.zero_bus ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG:  state_next = ST_SIN;
            ST_SIN:  state_next = ST_COS;
            ST_COS:  state_next = ST_ROT1;
            ST_ROT1: state_next = ST_ROT2;
            ST_ROT2: state_next = ST_SUM;
            ST_SUM:  state_next = ST_BS;
            ST_BS:   state_next = ST_SECT;
            ST_SECT: state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:
            begin
                cnt_next   = '0;
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                bus_reg      <= req.bus;
                q_neg_reg    <= req.q_neg;
                d_neg_reg    <= req.d_neg;
                ang_neg_reg  <= req.ang_neg;
                qdiv_reg     <= '{rem: 15'(q_prod[29:16]), sh: q_prod[15:0], quo: '0};
                ddiv_reg     <= '{rem: 15'(d_prod[29:16]), sh: d_prod[15:0], quo: '0};
                arem_reg     <= '0;
                ash_reg      <= req.ang_mag;
                sector_reg   <= SECTOR_NONE;
                duty_a_reg   <= '0;
                duty_b_reg   <= '0;
                duty_c_reg   <= '0;
            end
            ST_DIV:
            begin
                qdiv_reg  <= qdiv_next;
                ddiv_reg  <= ddiv_next;
                afold_reg <= ang_fold2;
                arem_reg  <= (AW'(ang_rem) << SH) | AW'(ash_reg & LOW_M);
            end
            ST_ANG:
            begin
                ang_reg   <= ang_fix;
                ang90_reg <= (ang90_sum >= {1'b0, FULL_A}) ? AW'(ang90_sum - {1'b0, FULL_A})
                                                           : ang90_sum[AW-1:0];
                uq_reg    <= q_neg_reg ? -$signed(qdiv_reg.quo) : $signed(qdiv_reg.quo);
                ud_reg    <= d_neg_reg ? -$signed(ddiv_reg.quo) : $signed(ddiv_reg.quo);
            end
            ST_SIN: s_reg <= trig_out;
            ST_COS: c_reg <= trig_out;
            ST_ROT1:
            begin
                pa_reg <= 33'(ud_reg) * 33'(c_reg);
                pb_reg <= 33'(uq_reg) * 33'(s_reg);
            end
            ST_ROT2:
            begin
                alpha_reg <= 34'(pa_reg) - 34'(pb_reg);
                pa_reg    <= 33'(ud_reg) * 33'(s_reg);
                pb_reg    <= 33'(uq_reg) * 33'(c_reg);
            end
            ST_SUM: beta_reg <= 34'(pa_reg) + 34'(pb_reg);
            ST_BS:  bs_reg   <= TW'(beta_reg) * K_INV;
            ST_SECT:
            begin
                sector_reg <= sector_w;
                t1_reg     <= t1_w;
                t2_reg     <= t2_w;
            end
            ST_T0: t0_reg <= (ONE - t1_reg - t2_reg) >>> 1;
            ST_T1:
            begin
                case (sector_reg)
                    SECTOR_1:
                    begin
                        ta_reg <= t0_reg; tb_reg <= t0_reg + t1_reg;
                        tc_reg <= t0_reg + t1_reg + t2_reg;
                    end
                    SECTOR_2:
                    begin
                        tb_reg <= t0_reg; ta_reg <= t0_reg + t2_reg;
                        tc_reg <= t0_reg + t2_reg + t1_reg;
                    end
                    SECTOR_3:
                    begin
                        tb_reg <= t0_reg; tc_reg <= t0_reg + t1_reg;
                        ta_reg <= t0_reg + t1_reg + t2_reg;
                    end
                    SECTOR_4:
                    begin
                        tc_reg <= t0_reg; tb_reg <= t0_reg + t2_reg;
                        ta_reg <= t0_reg + t2_reg + t1_reg;
                    end
                    SECTOR_5:
                    begin
                        tc_reg <= t0_reg; ta_reg <= t0_reg + t1_reg;
                        tb_reg <= t0_reg + t1_reg + t2_reg;
                    end
                    default:
                    begin
                        ta_reg <= t0_reg; tc_reg <= t0_reg + t2_reg;
                        tb_reg <= t0_reg + t2_reg + t1_reg;
                    end
                endcase
            end
            ST_DUTY:
            begin
                case (cnt_reg)
                    3'd0:    duty_a_reg <= duty_prod[61:46];
                    3'd1:    duty_b_reg <= duty_prod[61:46];
                    default: duty_c_reg <= duty_prod[61:46];
                endcase
            end
            default:
            begin
            end
        endcase
        if (rsp_load)
        begin
            rsp_a_reg      <= duty_a_reg;
            rsp_b_reg      <= duty_b_reg;
            rsp_c_reg      <= duty_c_reg;
            rsp_sector_reg <= sector_reg;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.pwm_a  = rsp_a_reg;
    assign rsp.pwm_b  = rsp_b_reg;
    assign rsp.pwm_c  = rsp_c_reg;
    assign rsp.sector = rsp_sector_reg;

endmodule
